[rtl/four_level_page_table_walker_unit_defines.svh]
// assertion macros for the page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define PGTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that must hold in the cycle after a trigger
`define PGTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define PGTW_ASSERT(lbl, prop, msg)
`define PGTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/pgtw_pkg.sv]
// shared types, constants and helpers of the page table walker
package pgtw_pkg;

  localparam int unsigned TablePagesDef = 64;
  localparam int unsigned EntryW        = 64;
  localparam int unsigned PfnW          = 40;
  localparam int unsigned VpnW          = 36;
  localparam int unsigned IdxW          = 9;
  localparam logic [IdxW-1:0] IdxLast   = '1;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_MAP       = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_NOPAGE = 2'd1,
    ERR_RANGE  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_LINK
  } state_e;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_e;

  // result of the shared address unit
  typedef struct packed {
    logic [PfnW-1:0] sum;
    logic            in_range;
  } alu_res_t;

  // memory port command
  typedef struct packed {
    logic              we;
    logic              re;
    logic [EntryW-1:0] wdata;
  } mem_cmd_t;

  // 9-bit table index of a level, root first
  function automatic logic [IdxW-1:0] level_idx(logic [VpnW-1:0] vpn, logic [1:0] level);
    logic [IdxW-1:0] idx;
    case (level)
      2'd0:    idx = vpn[35:27];
      2'd1:    idx = vpn[26:18];
      2'd2:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
    return idx;
  endfunction

endpackage

[rtl/pgtw_table_mem.sv]
// single-port table store with registered read data
module pgtw_table_mem import pgtw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TablePagesDef
) (
  input  logic                                       clk_i,
  input  logic [$clog2(TABLE_PAGES)+IdxW-1:0]        addr_i,
  input  mem_cmd_t                                   cmd_i,
  output logic [EntryW-1:0]                          rdata_o
);

  localparam int unsigned Depth = TABLE_PAGES * (2 ** IdxW);

  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;

  // one access per cycle: write or read
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[addr_i] <= cmd_i.wdata;
    end else if (cmd_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pgtw_addr_alu.sv]
// shared frame-number adder with table range check
module pgtw_addr_alu import pgtw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TablePagesDef
) (
  input  alu_op_e         op_i,
  input  logic [PfnW-1:0] a_i,
  input  logic [PfnW-1:0] b_i,
  output alu_res_t        res_o
);

  logic [PfnW-1:0] sum;

  // pointer minus base gives page offset, base plus page gives pointer
  always_comb begin
    case (op_i)
      ALU_ADD: sum = a_i + b_i;
      default: sum = a_i - b_i;
    endcase
  end

  assign res_o.sum      = sum;
  assign res_o.in_range = (sum < PfnW'(TABLE_PAGES));

endmodule

[rtl/four_level_page_table_walker_unit.sv]
// top level: four-level page table walker sequencer
//
// Translate or map a 48-bit virtual address against a four-level table held
// in a local single-port memory of TABLE_PAGES pages of 512 entries. An item
// is taken when start is high and busy is low; its single result appears for
// one cycle with done_o and cannot be held off. Each level takes a read step
// and then an evaluate step on the memory port. A map that creates a level
// zeroes the new page first. After reset the table store is swept to zero
// with busy high; configuration writes are taken during that sweep and
// whenever busy is low.
`include "four_level_page_table_walker_unit_defines.svh"
module four_level_page_table_walker_unit import pgtw_pkg::*; #(
  parameter int unsigned TABLE_PAGES = TablePagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [51:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [47:0] virt_addr_i,
  input  logic [51:0] phys_addr_i,
  input  logic [1:0]  access_flags_i,
  output logic        done_o,
  output logic [51:0] frame_addr_o,
  output logic        found_o,
  output logic [1:0]  error_code_o
);

  localparam int unsigned PageW = $clog2(TABLE_PAGES);
  localparam int unsigned NfW   = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AddrW = PageW + IdxW;

  // control state
  state_e            state_q, state_d;
  logic [1:0]        level_q, level_d;
  logic [NfW-1:0]    nfp_q, nfp_d;
  logic [IdxW-1:0]   clr_idx_q, clr_idx_d;
  logic [PageW-1:0]  clr_page_q, clr_page_d;
  logic              clr_all_q, clr_all_d;
  logic [PfnW-1:0]   base_q, base_d;
  logic              done_q, done_d;

  // payload
  cmd_e              cmd_q, cmd_d;
  logic [VpnW-1:0]   vpn_q, vpn_d;
  logic [PfnW-1:0]   pfn_q, pfn_d;
  logic [1:0]        req_q, req_d;
  logic [PageW-1:0]  page_q, page_d;
  logic [PageW-1:0]  alloc_page_q, alloc_page_d;
  logic [PfnW-1:0]   frame_q, frame_d;
  logic              found_q, found_d;
  err_e              err_q, err_d;

  // datapath wires
  logic [AddrW-1:0]  mem_addr;
  mem_cmd_t          mem_cmd;
  logic [EntryW-1:0] rdata;
  alu_op_e           alu_op;
  logic [PfnW-1:0]   alu_a, alu_b;
  alu_res_t          alu_res;

  pgtw_table_mem #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_mem (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .cmd_i  (mem_cmd),
    .rdata_o(rdata)
  );

  pgtw_addr_alu #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .res_o(alu_res)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      level_q    <= '0;
      nfp_q      <= NfW'(1);
      clr_idx_q  <= '0;
      clr_page_q <= '0;
      clr_all_q  <= 1'b1;
      base_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      level_q    <= level_d;
      nfp_q      <= nfp_d;
      clr_idx_q  <= clr_idx_d;
      clr_page_q <= clr_page_d;
      clr_all_q  <= clr_all_d;
      base_q     <= base_d;
      done_q     <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    vpn_q        <= vpn_d;
    pfn_q        <= pfn_d;
    req_q        <= req_d;
    page_q       <= page_d;
    alloc_page_q <= alloc_page_d;
    frame_q      <= frame_d;
    found_q      <= found_d;
    err_q        <= err_d;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    nfp_d        = nfp_q;
    clr_idx_d    = clr_idx_q;
    clr_page_d   = clr_page_q;
    clr_all_d    = clr_all_q;
    base_d       = base_q;
    done_d       = 1'b0;
    cmd_d        = cmd_q;
    vpn_d        = vpn_q;
    pfn_d        = pfn_q;
    req_d        = req_q;
    page_d       = page_q;
    alloc_page_d = alloc_page_q;
    frame_d      = frame_q;
    found_d      = found_q;
    err_d        = err_q;
    mem_addr     = {page_q, level_idx(vpn_q, level_q)};
    mem_cmd      = '0;
    alu_op       = ALU_SUB;
    alu_a        = rdata[51:12];
    alu_b        = base_q;

    // configuration transaction
    if (cfg_valid_i && cfg_ready_o) begin
      base_d = cfg_data_i[51:12];
    end

    unique case (state_q)
      // zero one entry per cycle: whole store after reset, one page on allocation
      ST_CLEAR: begin
        mem_addr      = {clr_page_q, clr_idx_q};
        mem_cmd.we    = 1'b1;
        clr_idx_d     = clr_idx_q + IdxW'(1);
        if (clr_idx_q == IdxLast) begin
          if (clr_all_q && (clr_page_q != PageW'(TABLE_PAGES - 1))) begin
            clr_page_d = clr_page_q + PageW'(1);
          end else if (clr_all_q) begin
            clr_all_d = 1'b0;
            state_d   = ST_IDLE;
          end else begin
            state_d = ST_LINK;
          end
        end
      end

      // accept a transaction
      ST_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(cmd_i);
          vpn_d   = virt_addr_i[47:12];
          pfn_d   = phys_addr_i[51:12];
          req_d   = access_flags_i;
          page_d  = '0;
          level_d = '0;
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        mem_cmd.re = 1'b1;
        state_d    = ST_EVAL;
      end

      // look at the entry of this level
      ST_EVAL: begin
        if (level_q == 2'd3) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          err_d   = ERR_OK;
          if (cmd_q == CMD_MAP) begin
            mem_cmd.we    = 1'b1;
            mem_cmd.wdata = {12'b0, pfn_q, 9'b0, req_q, 1'b1};
            frame_d       = pfn_q;
            found_d       = 1'b1;
          end else if (rdata[0]) begin
            frame_d = rdata[51:12];
            found_d = 1'b1;
          end else begin
            frame_d = '0;
            found_d = 1'b0;
          end
        end else if (!rdata[0]) begin
          if (cmd_q == CMD_TRANSLATE) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
            frame_d = '0;
            found_d = 1'b0;
            err_d   = ERR_OK;
          end else if (nfp_q == NfW'(TABLE_PAGES)) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
            frame_d = '0;
            found_d = 1'b0;
            err_d   = ERR_NOPAGE;
          end else begin
            // take a fresh page and zero it before linking
            alloc_page_d = nfp_q[PageW-1:0];
            nfp_d        = nfp_q + NfW'(1);
            clr_page_d   = nfp_q[PageW-1:0];
            clr_idx_d    = '0;
            clr_all_d    = 1'b0;
            state_d      = ST_CLEAR;
          end
        end else begin
          if (cmd_q == CMD_MAP) begin
            mem_cmd.we    = 1'b1;
            mem_cmd.wdata = rdata | {61'b0, req_q, 1'b0};
          end
          if (!alu_res.in_range) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
            frame_d = '0;
            found_d = 1'b0;
            err_d   = ERR_RANGE;
          end else begin
            page_d  = alu_res.sum[PageW-1:0];
            level_d = level_q + 2'd1;
            state_d = ST_READ;
          end
        end
      end

      // write the pointer to the new page into the parent entry
      ST_LINK: begin
        alu_op        = ALU_ADD;
        alu_a         = base_q;
        alu_b         = PfnW'(alloc_page_q);
        mem_cmd.we    = 1'b1;
        mem_cmd.wdata = {12'b0, alu_res.sum, 9'b0, req_q, 1'b1};
        page_d        = alloc_page_q;
        level_d       = level_q + 2'd1;
        state_d       = ST_READ;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // base register only changes between walks
  assign cfg_ready_o  = (state_q == ST_IDLE) || clr_all_q;
  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign frame_addr_o = {frame_q, 12'b0};
  assign found_o      = found_q;
  assign error_code_o = err_q;

  `PGTW_ASSERT(a_found_no_err, done_q && found_q |-> err_q == ERR_OK, "found with error")
  `PGTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `PGTW_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")
  `PGTW_ASSERT(a_nfp_range, nfp_q != '0 && nfp_q <= NfW'(TABLE_PAGES), "allocator out of range")

endmodule
